// ===== rtl/core/cwc_pkg.sv =====
// shared types and constants for the color window classifier sequencer
// no dependencies; used by every module of the block through scoped names
package cwc_pkg;

   // table and sample sizes
   localparam int NUM_FILTERS = 4;
   localparam int SAMPLE_BITS = 16;
   localparam int NUM_CHANNELS = 3;
   localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

   // csr register indexes
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNDEF_CODE = 8'd1;

   // csr reset values
   localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;
   localparam logic [3:0] UNDEF_CODE_RESET = 4'd15;
   localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_EVENT  = 2'd1,
      KIND_SAMPLE = 2'd2,
      KIND_FILTER = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_WAIT     = 3'd0,
      PH_LED_ON   = 3'd1,
      PH_SETTLE   = 3'd2,
      PH_MEASURE  = 3'd3,
      PH_LED_OFF  = 3'd4,
      PH_CLASSIFY = 3'd5,
      PH_MARK     = 3'd6
   } phase_type;

   // one input word
   typedef struct packed {
      kind_type    kind;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [1:0]  filter_index;
      logic [1:0]  channel;
      logic        use_flag;
      logic [15:0] low_bound;
      logic [15:0] high_bound;
   } item_type;

   // one result word
   typedef struct packed {
      phase_type  phase;
      logic       led_on;
      logic       object_present;
      logic [3:0] color;
      logic       report;
   } result_type;

endpackage

// ===== rtl/core/color_window_classifier_sequencer_core.sv =====
// top level: input register, csr registers, result register
// depends on cwc_pkg, cwc_filter_bank and cwc_sequencer
//
// Takes one word per clock and returns one result word per input word. Each
// accepted word waits in the input register until the result register can take
// its result; the result word is then registered there. Every word is applied
// between the input register and the result register (sequencer state update
// plus a parallel window compare of all filters), so a new word can follow in
// every cycle; the input side stalls only while the result register holds an
// untaken word. CSR writes are always accepted.
module color_window_classifier_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_red,
   input  logic [15:0] req_green,
   input  logic [15:0] req_blue,
   input  logic [1:0]  req_filter_index,
   input  logic [1:0]  req_channel,
   input  logic        req_use_flag,
   input  logic [15:0] req_low_bound,
   input  logic [15:0] req_high_bound,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_phase,
   output logic        rsp_led_on,
   output logic        rsp_object_present,
   output logic [3:0]  rsp_color,
   output logic        rsp_report,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [cwc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0] csr_data
);

   logic                item_valid_ff;
   cwc_pkg::item_type   item_ff;
   logic                rsp_valid_ff;
   cwc_pkg::result_type rsp_ff;
   cwc_pkg::result_type result;
   logic [31:0]         timeout_ff;
   logic [3:0]          undef_code_ff;
   logic [3:0]          class_code;
   logic                fire;

   // a word is applied when the result register can take its result
   assign fire      = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || fire;
   assign csr_ready = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= cwc_pkg::TIMEOUT_RESET;
         undef_code_ff <= cwc_pkg::UNDEF_CODE_RESET;
      end else if (csr_valid) begin
         if (csr_index == cwc_pkg::CSR_TIMEOUT) begin
            timeout_ff <= csr_data;
         end else if (csr_index == cwc_pkg::CSR_UNDEF_CODE) begin
            undef_code_ff <= csr_data[3:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.kind         <= cwc_pkg::kind_type'(req_kind);
         item_ff.red          <= req_red;
         item_ff.green        <= req_green;
         item_ff.blue         <= req_blue;
         item_ff.filter_index <= req_filter_index;
         item_ff.channel      <= req_channel;
         item_ff.use_flag     <= req_use_flag;
         item_ff.low_bound    <= req_low_bound;
         item_ff.high_bound   <= req_high_bound;
      end
   end

   cwc_filter_bank u_filter_bank (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (item_ff),
      .undefined_code (undef_code_ff),
      .class_code     (class_code)
   );

   cwc_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (item_ff),
      .timeout_ticks (timeout_ff),
      .class_code    (class_code),
      .result        (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_phase          = rsp_ff.phase;
   assign rsp_led_on         = rsp_ff.led_on;
   assign rsp_object_present = rsp_ff.object_present;
   assign rsp_color          = rsp_ff.color;
   assign rsp_report         = rsp_ff.report;

endmodule

// ===== rtl/core/cwc_filter_bank.sv =====
// filter table, latest color sample and the parallel window match
// depends on cwc_pkg for the item type and table sizes
module cwc_filter_bank (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  cwc_pkg::item_type     item,
   input  logic [3:0]            undefined_code,
   output logic [3:0]            class_code
);

   logic [15:0] sample_ff [cwc_pkg::NUM_CHANNELS];
   logic [cwc_pkg::NUM_CHANNELS-1:0] enable_ff [cwc_pkg::NUM_FILTERS];
   logic [15:0] low_ff  [cwc_pkg::NUM_FILTERS][cwc_pkg::NUM_CHANNELS];
   logic [15:0] high_ff [cwc_pkg::NUM_FILTERS][cwc_pkg::NUM_CHANNELS];
   logic [cwc_pkg::NUM_FILTERS-1:0] hit;
   logic sample_wr;
   logic filter_wr;

   assign sample_wr = fire && (item.kind == cwc_pkg::KIND_SAMPLE);
   assign filter_wr = fire && (item.kind == cwc_pkg::KIND_FILTER);

   // latest sample, masked to the sample width
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < cwc_pkg::NUM_CHANNELS; c++) begin
            sample_ff[c] <= '0;
         end
      end else if (sample_wr) begin
         sample_ff[0] <= item.red & cwc_pkg::SAMPLE_MASK;
         sample_ff[1] <= item.green & cwc_pkg::SAMPLE_MASK;
         sample_ff[2] <= item.blue & cwc_pkg::SAMPLE_MASK;
      end
   end

   // channel enables, cleared at reset so every filter matches
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < cwc_pkg::NUM_FILTERS; f++) begin
            enable_ff[f] <= '0;
         end
      end else if (filter_wr) begin
         for (int f = 0; f < cwc_pkg::NUM_FILTERS; f++) begin
            for (int c = 0; c < cwc_pkg::NUM_CHANNELS; c++) begin
               if (32'(item.filter_index) == f && 32'(item.channel) == c) begin
                  enable_ff[f][c] <= item.use_flag;
               end
            end
         end
      end
   end

   // window bounds, only read once their channel is enabled
   always_ff @(posedge clock) begin
      if (filter_wr) begin
         for (int f = 0; f < cwc_pkg::NUM_FILTERS; f++) begin
            for (int c = 0; c < cwc_pkg::NUM_CHANNELS; c++) begin
               if (32'(item.filter_index) == f && 32'(item.channel) == c) begin
                  low_ff[f][c]  <= item.low_bound;
                  high_ff[f][c] <= item.high_bound;
               end
            end
         end
      end
   end

   // per-filter window test over the enabled channels
   always_comb begin
      for (int f = 0; f < cwc_pkg::NUM_FILTERS; f++) begin
         hit[f] = 1'b1;
         for (int c = 0; c < cwc_pkg::NUM_CHANNELS; c++) begin
            if (enable_ff[f][c] &&
                (sample_ff[c] < low_ff[f][c] || sample_ff[c] > high_ff[f][c])) begin
               hit[f] = 1'b0;
            end
         end
      end
   end

   // highest matching filter wins
   always_comb begin
      class_code = undefined_code;
      for (int f = 0; f < cwc_pkg::NUM_FILTERS; f++) begin
         if (hit[f]) begin
            class_code = 4'(f);
         end
      end
   end

endmodule

// ===== rtl/core/cwc_sequencer.sv =====
// measurement phase sequencer, object flag timeout and color register
// depends on cwc_pkg; takes the classification code from cwc_filter_bank
module cwc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  cwc_pkg::item_type      item,
   input  logic [31:0]            timeout_ticks,
   input  logic [3:0]             class_code,
   output cwc_pkg::result_type    result
);

   cwc_pkg::phase_type phase_ff, phase_in;
   logic        event_ff, event_in;
   logic        led_ff, led_in;
   logic        object_ff, object_in;
   logic [3:0]  color_ff, color_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        report;
   logic        elapsed_sat;
   logic        timed_out;

   // saturating elapsed + 1 > timeout, without the adder in the compare path
   assign elapsed_sat = (elapsed_ff == cwc_pkg::ELAPSED_MAX);
   assign timed_out = elapsed_sat ? (timeout_ticks != cwc_pkg::ELAPSED_MAX)
                                  : (elapsed_ff >= timeout_ticks);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cwc_pkg::PH_WAIT;
         event_ff   <= 1'b0;
         led_ff     <= 1'b0;
         object_ff  <= 1'b0;
         color_ff   <= cwc_pkg::UNDEF_CODE_RESET;
         elapsed_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         event_ff   <= event_in;
         led_ff     <= led_in;
         object_ff  <= object_in;
         color_ff   <= color_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // next state for one word
   always_comb begin
      phase_in   = phase_ff;
      event_in   = event_ff;
      led_in     = led_ff;
      object_in  = object_ff;
      color_in   = color_ff;
      elapsed_in = elapsed_ff;
      report     = 1'b0;
      if (item.kind == cwc_pkg::KIND_EVENT) begin
         event_in = 1'b1;
      end else if (item.kind == cwc_pkg::KIND_TICK) begin
         elapsed_in = elapsed_sat ? elapsed_ff : elapsed_ff + 32'd1;
         unique case (phase_ff)
            cwc_pkg::PH_WAIT: begin
               if (event_ff) begin
                  event_in = 1'b0;
                  report   = 1'b1;
                  phase_in = cwc_pkg::PH_LED_ON;
               end else if (object_ff && timed_out) begin
                  object_in = 1'b0;
               end
            end
            cwc_pkg::PH_LED_ON: begin
               led_in   = 1'b1;
               phase_in = cwc_pkg::PH_SETTLE;
            end
            cwc_pkg::PH_SETTLE: begin
               phase_in = cwc_pkg::PH_MEASURE;
            end
            cwc_pkg::PH_MEASURE: begin
               phase_in = cwc_pkg::PH_LED_OFF;
            end
            cwc_pkg::PH_LED_OFF: begin
               led_in   = 1'b0;
               phase_in = cwc_pkg::PH_CLASSIFY;
            end
            cwc_pkg::PH_CLASSIFY: begin
               color_in = class_code;
               phase_in = cwc_pkg::PH_MARK;
            end
            cwc_pkg::PH_MARK: begin
               phase_in   = cwc_pkg::PH_WAIT;
               elapsed_in = '0;
               object_in  = 1'b1;
            end
            default: begin
               phase_in = cwc_pkg::PH_WAIT;
            end
         endcase
      end
   end

   // result word reflects the state after this word
   assign result.phase          = phase_in;
   assign result.led_on         = led_in;
   assign result.object_present = object_in;
   assign result.color          = color_in;
   assign result.report         = report;

endmodule

// ===== rtl/core/cwc_checker.sv =====
// port-level checks for the color window classifier sequencer
// bound to color_window_classifier_sequencer_core; phase codes from cwc_pkg
module cwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_phase,
   input logic       rsp_led_on,
   input logic       rsp_report
);

   // response stays put while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase) && $stable(rsp_report))
      else $error("response changed while stalled");

   // no response right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // led is driven exactly in settle, measure and led off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_led_on == (rsp_phase == cwc_pkg::PH_SETTLE ||
                                   rsp_phase == cwc_pkg::PH_MEASURE ||
                                   rsp_phase == cwc_pkg::PH_LED_OFF))
      else $error("led state does not match phase");

   // a report starts the led on phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report |-> rsp_phase == cwc_pkg::PH_LED_ON)
      else $error("report outside the led on phase");

endmodule

bind color_window_classifier_sequencer_core cwc_checker u_cwc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_phase  (rsp_phase),
   .rsp_led_on (rsp_led_on),
   .rsp_report (rsp_report)
);
